@@ hw/rtl/connection_and_request_limiter_assert.svh @@
// Assertion macros for the connection and request limiter.
// Included by connection_and_request_limiter.sv; no other dependencies.
`ifndef CONNECTION_AND_REQUEST_LIMITER_ASSERT_SVH
`define CONNECTION_AND_REQUEST_LIMITER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CRL_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("limiter assertion failed");

// Next-cycle implication, checked outside reset
`define CRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("limiter assertion failed");

`endif

@@ hw/rtl/crl_pkg.sv @@
// Package for the connection and request limiter: payload structs, codes, widths.
// No dependencies; imported by connection_and_request_limiter.sv.
`timescale 1ns / 1ps
`default_nettype none

package crl_pkg;

    localparam int ADDR_W     = 64;
    localparam int COUNT_W    = 20;
    localparam int TIME_W     = 40;
    localparam int WIN_W      = 16;
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int DEFAULT_TABLE_ENTRIES = 64;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // Limit kinds
    localparam logic [KIND_W-1:0] KIND_TOTAL       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLIENT_CONN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WINDOW      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLIENT_REQ  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS  = 2'd2;

    // Register reset values
    localparam logic [KIND_W-1:0]  RST_LIMIT_KIND = KIND_TOTAL;
    localparam logic [COUNT_W-1:0] RST_LIMIT      = 20'd1;
    localparam logic [WIN_W-1:0]   RST_WINDOW_MS  = 16'd1000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic               admitted;
        logic               over_limit;
        logic               table_full;
        logic [COUNT_W-1:0] count_after;
    } t_result;

    // One client table entry
    typedef struct packed {
        logic [ADDR_W-1:0]  addr_hi;
        logic [ADDR_W-1:0]  addr_lo;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  stamp;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/connection_and_request_limiter.sv @@
// Connection and request limiter: admits or rejects opens, releases on close, expires on tick.
// Depends on crl_pkg and connection_and_request_limiter_assert.svh.
//
//  Channel  | Signals                          | Transfer rule
//  ---------+----------------------------------+-----------------------------------
//  item in  | i_start, i_item, o_busy          | edge with i_start high, o_busy low
//  result   | o_done, o_result                 | one cycle per item, o_done high
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data  | edge with i_cfg_we high
//
// Total-connection and window items, and unknown modes, are done in the accept cycle:
// the result shows in the next cycle and o_busy stays low.
// Client-table items and ticks walk the table one entry per cycle through the single
// compare unit behind the table RAM read port: o_busy is high through ST_SCAN and
// ST_DONE, and the result shows in the cycle right after o_busy drops. Synchronous
// active-low reset clears the valid bits at once; no clearing pass. The receiver cannot
// stall results.
`timescale 1ns / 1ps
`default_nettype none

module connection_and_request_limiter
    import crl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item channel
    input  wire logic                  i_start,
    input  wire t_item                 i_item,
    output      logic                  o_busy,
    // result channel
    output      logic                  o_done,
    output      t_result               o_result,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int VCW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // Configuration registers
    logic [KIND_W-1:0]  r_kind;
    logic [COUNT_W-1:0] r_limit;
    logic [WIN_W-1:0]   r_window_ms;

    // Counters for the kinds without a table
    logic [COUNT_W-1:0] r_tc,     n_tc;
    logic [TIME_W-1:0]  r_wstart, n_wstart;
    logic [COUNT_W-1:0] r_wc,     n_wc;

    // Sequencer
    t_state             r_state, n_state;
    t_item              r_item,  n_item;
    logic [IW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_rd_act, n_rd_act;
    logic               r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]      r_cmp_idx, n_cmp_idx;
    logic               r_found, n_found;
    logic [IW-1:0]      r_ent_idx, n_ent_idx;
    t_entry             r_ent, n_ent;
    logic               r_free_found, n_free_found;
    logic [IW-1:0]      r_free_idx, n_free_idx;
    logic [VCW-1:0]     r_vcnt, n_vcnt;

    // Client table: valid flops plus entry RAM
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    t_entry             r_mem [TABLE_ENTRIES];
    t_entry             r_rdata;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    t_entry             mem_wdata;

    // Result register
    t_result            r_res, n_res;
    logic               r_res_stb, n_res_stb;

    // Shared compare unit and helpers
    logic               needs_scan;
    logic               cur_valid;
    logic               hit;
    logic               expire;
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  win_age;
    logic [COUNT_W-1:0] wc_inc;
    logic [COUNT_W-1:0] ent_dec;

    assign o_busy   = (r_state != ST_IDLE);
    assign o_done   = r_res_stb;
    assign o_result = r_res;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= RST_LIMIT_KIND;
            r_limit     <= RST_LIMIT;
            r_window_ms <= RST_WINDOW_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIMIT_KIND: r_kind      <= i_cfg_data[KIND_W-1:0];
                CFG_LIMIT:      r_limit     <= i_cfg_data[COUNT_W-1:0];
                CFG_WINDOW_MS:  r_window_ms <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Table RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_rd_idx];
    end

    assign needs_scan = (i_item.mode == MODE_TICK)
                     || (((i_item.mode == MODE_OPEN) || (i_item.mode == MODE_CLOSE))
                         && ((r_kind == KIND_CLIENT_CONN) || (r_kind == KIND_CLIENT_REQ)));

    // Per-entry compare on the registered read data
    assign cur_valid = r_valid[r_cmp_idx];
    assign hit       = cur_valid && (r_rdata.addr_hi == r_item.addr_hi)
                                 && (r_rdata.addr_lo == r_item.addr_lo);
    assign age       = r_item.now_ms - r_rdata.stamp;
    assign expire    = cur_valid && (r_item.mode == MODE_TICK) && (r_kind == KIND_CLIENT_REQ)
                    && (age >= TIME_W'(r_window_ms));

    assign win_age = i_item.now_ms - r_wstart;
    assign wc_inc  = (r_wc != '1) ? (r_wc + COUNT_W'(1)) : r_wc;
    assign ent_dec = (r_ent.count != '0) ? (r_ent.count - COUNT_W'(1)) : '0;

    // Next state and datapath
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_tc         = r_tc;
        n_wstart     = r_wstart;
        n_wc         = r_wc;
        n_valid      = r_valid;
        n_rd_idx     = r_rd_idx;
        n_rd_act     = r_rd_act;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_rd_idx;
        n_found      = r_found;
        n_ent_idx    = r_ent_idx;
        n_ent        = r_ent;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_vcnt       = r_vcnt;
        n_res        = r_res;
        n_res_stb    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_ent_idx;
        mem_wdata    = r_ent;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    if (needs_scan) begin
                        n_state      = ST_SCAN;
                        n_rd_idx     = '0;
                        n_rd_act     = 1'b1;
                        n_found      = 1'b0;
                        n_free_found = 1'b0;
                        n_vcnt       = '0;
                    end else begin
                        // Total-connection and window items finish here
                        n_res     = '0;
                        n_res_stb = 1'b1;
                        priority if (i_item.mode == MODE_OPEN) begin
                            if (r_kind == KIND_TOTAL) begin
                                if (r_tc < r_limit) begin
                                    n_tc           = r_tc + COUNT_W'(1);
                                    n_res.admitted = 1'b1;
                                end else begin
                                    n_res.over_limit = 1'b1;
                                end
                                n_res.count_after = n_tc;
                            end else if (win_age > TIME_W'(r_window_ms)) begin
                                n_wstart          = i_item.now_ms;
                                n_wc              = COUNT_W'(1);
                                n_res.admitted    = 1'b1;
                                n_res.count_after = COUNT_W'(1);
                            end else begin
                                n_wc = wc_inc;
                                if (wc_inc > r_limit) begin
                                    n_res.over_limit = 1'b1;
                                end else begin
                                    n_res.admitted = 1'b1;
                                end
                                n_res.count_after = wc_inc;
                            end
                        end else if (i_item.mode == MODE_CLOSE) begin
                            if (r_kind == KIND_TOTAL) begin
                                if (r_tc != '0) begin
                                    n_tc = r_tc - COUNT_W'(1);
                                end
                                n_res.count_after = n_tc;
                            end else begin
                                n_res.count_after = r_wc;
                            end
                        end else begin
                            // unknown mode: all-zero result
                            n_res = '0;
                        end
                    end
                end
            end

            ST_SCAN: begin
                // issue side
                if (r_rd_act) begin
                    n_rd_idx = r_rd_idx + IW'(1);
                    if (r_rd_idx == LAST_IDX) begin
                        n_rd_act = 1'b0;
                    end
                end
                n_cmp_vld = r_rd_act;
                n_cmp_idx = r_rd_idx;
                // compare side, one entry behind
                if (r_cmp_vld) begin
                    if (hit && !r_found) begin
                        n_found   = 1'b1;
                        n_ent_idx = r_cmp_idx;
                        n_ent     = r_rdata;
                    end
                    if (!cur_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cmp_idx;
                    end
                    if (expire) begin
                        n_valid[r_cmp_idx] = 1'b0;
                    end else if (cur_valid) begin
                        n_vcnt = r_vcnt + VCW'(1);
                    end
                    if (r_cmp_idx == LAST_IDX) begin
                        n_state = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                n_state   = ST_IDLE;
                n_res     = '0;
                n_res_stb = 1'b1;
                priority if (r_item.mode == MODE_OPEN) begin
                    if (r_found) begin
                        if (r_ent.count < r_limit) begin
                            mem_we            = 1'b1;
                            mem_waddr         = r_ent_idx;
                            mem_wdata         = r_ent;
                            mem_wdata.count   = r_ent.count + COUNT_W'(1);
                            n_res.admitted    = 1'b1;
                            n_res.count_after = r_ent.count + COUNT_W'(1);
                        end else begin
                            n_res.over_limit  = 1'b1;
                            n_res.count_after = r_ent.count;
                        end
                    end else if ((r_kind == KIND_CLIENT_CONN) && (r_limit == '0)) begin
                        n_res.over_limit = 1'b1;
                    end else if (r_free_found) begin
                        // new client takes the lowest free entry
                        mem_we              = 1'b1;
                        mem_waddr           = r_free_idx;
                        mem_wdata.addr_hi   = r_item.addr_hi;
                        mem_wdata.addr_lo   = r_item.addr_lo;
                        mem_wdata.count     = COUNT_W'(1);
                        mem_wdata.stamp     = r_item.now_ms;
                        n_valid[r_free_idx] = 1'b1;
                        n_res.admitted      = 1'b1;
                        n_res.count_after   = COUNT_W'(1);
                    end else begin
                        n_res.table_full = 1'b1;
                    end
                end else if (r_item.mode == MODE_CLOSE) begin
                    if (r_found) begin
                        if (r_kind == KIND_CLIENT_CONN) begin
                            if (ent_dec == '0) begin
                                n_valid[r_ent_idx] = 1'b0;
                            end else begin
                                mem_we            = 1'b1;
                                mem_waddr         = r_ent_idx;
                                mem_wdata         = r_ent;
                                mem_wdata.count   = ent_dec;
                                n_res.count_after = ent_dec;
                            end
                        end else begin
                            n_res.count_after = r_ent.count;
                        end
                    end
                end else begin
                    // tick: valid entries left
                    n_res.count_after = COUNT_W'(r_vcnt);
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tc      <= '0;
            r_wstart  <= '0;
            r_wc      <= '0;
            r_valid   <= '0;
            r_rd_act  <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_res_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tc      <= n_tc;
            r_wstart  <= n_wstart;
            r_wc      <= n_wc;
            r_valid   <= n_valid;
            r_rd_act  <= n_rd_act;
            r_cmp_vld <= n_cmp_vld;
            r_res_stb <= n_res_stb;
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_rd_idx     <= n_rd_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_found      <= n_found;
        r_ent_idx    <= n_ent_idx;
        r_ent        <= n_ent;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_vcnt       <= n_vcnt;
        r_res        <= n_res;
    end

    // Checks
`include "connection_and_request_limiter_assert.svh"

    `CRL_ASSERT_HOLDS(a_flags_exclusive, i_clk, i_rst_n, r_res_stb,
        ($onehot0({r_res.admitted, r_res.over_limit, r_res.table_full})))
    `CRL_ASSERT_NEXT(a_scan_starts, i_clk, i_rst_n,
        (i_start && !o_busy && needs_scan), (r_state == ST_SCAN))
    `CRL_ASSERT_HOLDS(a_no_result_in_scan, i_clk, i_rst_n, (r_state == ST_SCAN), (!r_res_stb))
    `CRL_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n,
        (r_state == ST_DONE), (r_res_stb && (r_state == ST_IDLE)))

endmodule

`default_nettype wire
